/* src/cmapf4_pkg.sv */
package cmapf4_pkg;

  // default subtable storage in bytes
  localparam int MemBytesDefault = 4096;

  // internal offset width; covers every offset a query can form
  localparam int OffW = 20;

  // codepoint that never maps
  localparam logic [15:0] NonChar = 16'hFFFF;

  // byte offset of the endCode array
  localparam logic [OffW-1:0] EndsAt = OffW'(14);

  // result status codes
  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatTrunc = 2'd1;
  localparam logic [1:0] StatRange = 2'd2;

  // query sequencer states
  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StHdr  = 7'b0000010,
    StChk  = 7'b0000100,
    StSeg  = 7'b0001000,
    StEval = 7'b0010000,
    StInd  = 7'b0100000,
    StFin  = 7'b1000000
  } state_e;

endpackage

/* src/cmap_format4_glyph_lookup.sv */
// Glyph lookup over one TrueType cmap format 4 subtable held in a byte-wide
// RAM of MEM_BYTES entries. A word with kind_i low stores one subtable byte;
// bytes at or above MEM_BYTES are dropped. A word with kind_i high maps
// codepoint_i and yields one result word. Every access goes through the
// single RAM read port, one byte per cycle, so a query reads the header,
// then the four fields of each segment, plus the glyph entry for each
// covering segment whose glyph read lies within the stored length, and a
// finished query waits while the previous result is still held in a stalled
// output register. A truncated header, codepoint 0xFFFF or an empty segment
// list ends the query after the header check. The RAM is not cleared: bytes
// must be loaded before a query touches them. in_stall_o stays high while a
// query runs; a finished result waits in the output register and does not block further loads.
module cmap_format4_glyph_lookup
  import cmapf4_pkg::*;
#(
  parameter int MEM_BYTES = MemBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [11:0] byte_address_i,
  input  logic [7:0]  byte_value_i,
  input  logic [15:0] codepoint_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] glyph_id_o,
  output logic [1:0]  status_o
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [OffW-1:0] MemLimit = OffW'(MEM_BYTES);

  // subtable storage
  logic [7:0] mem_q [MEM_BYTES];
  logic [7:0] rdata_q;

  state_e state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       out_valid_q;

  logic [63:0]     sh_q;
  logic [15:0]     cp_q;
  logic [OffW-1:0] limit_q, starts_q, deltas_q, ranges_q, off_q, at_q;
  logic [14:0]     seg_q, segs_q;
  logic [15:0]     gid_q, delta_q, glyph_q;
  logic [1:0]      stat_q, status_q;

  logic            in_acc, wr_en, cap, out_free;
  logic [OffW-1:0] wr_addr, raddr, base;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign wr_addr     = {8'b0, byte_address_i};
  assign wr_en       = in_acc && !kind_i && (wr_addr < MemLimit);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign glyph_id_o  = glyph_q;
  assign status_o    = status_q;

  // store port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr[AW-1:0]] <= byte_value_i;
    end
    rdata_q <= mem_q[raddr[AW-1:0]];
  end

  // read address per phase
  always_comb begin
    case (step_q[2:1])
      2'd0:    base = EndsAt;
      2'd1:    base = starts_q;
      2'd2:    base = deltas_q;
      default: base = ranges_q;
    endcase
    case (state_q)
      StHdr:   raddr = (step_q < 4'd2) ? OffW'(2 + step_q) : OffW'(4 + step_q);
      StSeg:   raddr = base + off_q + OffW'(step_q[0]);
      StInd:   raddr = at_q + OffW'(step_q[0]);
      default: raddr = '0;
    endcase
  end

  // byte capture into the shift register
  always_comb begin
    case (state_q)
      StHdr, StSeg: cap = (step_q != 4'd0);
      StInd:        cap = (step_q == 4'd1) || (step_q == 4'd2);
      default:      cap = 1'b0;
    endcase
  end

  // header fields
  logic [15:0]     len_w, seg2_w;
  logic [OffW-1:0] len_x, seg2_x, need_w, limit_w;
  assign len_w   = sh_q[31:16];
  assign seg2_w  = sh_q[15:0];
  assign len_x   = {4'b0, len_w};
  assign seg2_x  = {4'b0, seg2_w};
  assign need_w  = {2'b0, seg2_w, 2'b0} + OffW'(16);
  assign limit_w = (len_x < MemLimit) ? len_x : MemLimit;

  // segment fields
  logic [15:0]     last_w, first_w, segdelta_w, range_w, diff_w, ind_w;
  logic            covered, last_seg;
  logic [OffW-1:0] at_w;
  assign last_w     = sh_q[63:48];
  assign first_w    = sh_q[47:32];
  assign segdelta_w = sh_q[31:16];
  assign range_w    = sh_q[15:0];
  assign diff_w     = cp_q - first_w;
  assign covered    = (first_w <= last_w) && (cp_q >= first_w) && (cp_q <= last_w);
  assign at_w       = ranges_q + off_q + {4'b0, range_w} + {3'b0, diff_w, 1'b0};
  assign last_seg   = (15'(seg_q + 15'd1) == segs_q);
  assign ind_w      = sh_q[15:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      StIdle: begin
        step_d = '0;
        if (in_acc && kind_i) state_d = StHdr;
      end
      StHdr: begin
        if (step_q == 4'd4) begin
          step_d  = '0;
          state_d = StChk;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      StChk: begin
        if (need_w > limit_w || cp_q == NonChar || seg2_w[15:1] == 15'd0) begin
          state_d = StFin;
        end else begin
          state_d = StSeg;
        end
      end
      StSeg: begin
        if (step_q == 4'd8) begin
          step_d  = '0;
          state_d = StEval;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      StEval: begin
        if (covered && range_w != 16'd0 && !(at_w + OffW'(2) > limit_q)) begin
          state_d = StInd;
        end else begin
          state_d = last_seg ? StFin : StSeg;
        end
      end
      StInd: begin
        if (step_q == 4'd3) begin
          step_d  = '0;
          state_d = last_seg ? StFin : StSeg;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      StFin: begin
        if (out_free) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
        step_d  = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == StFin && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cap) sh_q <= {sh_q[55:0], rdata_q};
    if (in_acc && kind_i) cp_q <= codepoint_i;
    if (state_q == StFin && out_free) begin
      glyph_q  <= gid_q;
      status_q <= stat_q;
    end
    case (state_q)
      StChk: begin
        limit_q  <= limit_w;
        segs_q   <= seg2_w[15:1];
        starts_q <= seg2_x + OffW'(16);
        deltas_q <= {3'b0, seg2_w, 1'b0} + OffW'(16);
        ranges_q <= seg2_x + {3'b0, seg2_w, 1'b0} + OffW'(16);
        seg_q    <= '0;
        off_q    <= '0;
        gid_q    <= '0;
        stat_q   <= (need_w > limit_w) ? StatTrunc : StatOk;
      end
      StEval: begin
        delta_q <= segdelta_w;
        at_q    <= at_w;
        if (covered) begin
          if (range_w == 16'd0) begin
            gid_q  <= cp_q + segdelta_w;
            stat_q <= StatOk;
          end else if (at_w + OffW'(2) > limit_q) begin
            gid_q  <= '0;
            stat_q <= StatRange;
          end
        end
        // advance unless the indirect read follows
        if (!(covered && range_w != 16'd0 && !(at_w + OffW'(2) > limit_q))) begin
          seg_q <= seg_q + 15'd1;
          off_q <= off_q + OffW'(2);
        end
      end
      StInd: begin
        if (step_q == 4'd3) begin
          gid_q  <= (ind_w != 16'd0) ? ind_w + delta_q : 16'd0;
          stat_q <= StatOk;
          seg_q  <= seg_q + 15'd1;
          off_q  <= off_q + OffW'(2);
        end
      end
      default: ;
    endcase
  end

endmodule

/* src/cmapf4_checker.sv */
module cmapf4_checker
  import cmapf4_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        kind_i,
  input logic [11:0] byte_address_i,
  input logic [7:0]  byte_value_i,
  input logic [15:0] codepoint_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] glyph_id_o,
  input logic [1:0]  status_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(glyph_id_o) && $stable(status_o))
    else $error("result word changed while stalled");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StatOk) || (status_o == StatTrunc) || (status_o == StatRange))
    else $error("undefined status code");

  // any error reports glyph 0
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatOk |-> glyph_id_o == 16'd0)
    else $error("nonzero glyph with error status");

  // an accepted query makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_i |=> in_stall_o)
    else $error("query accepted without going busy");

endmodule

bind cmap_format4_glyph_lookup cmapf4_checker u_cmapf4_checker (.*);
